// ----- rtl/vic_pkg.sv -----
// Package for the vertex index compactor: payload structs, command and
// status types between controller and datapath, and the scaling helper.
// No dependencies.
package vic_pkg;

  localparam int unsigned MAX_POINTS_DEF = 4096;
  localparam int unsigned MAP_LIMIT      = 4096;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned PROD_W  = COORD_W + SCALE_W + 1;
  localparam int unsigned FRAC_W  = 16;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
  localparam logic [CNT_W-1:0]   LIMIT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    REG_SCALE_X     = 2'd0,
    REG_SCALE_Y     = 2'd1,
    REG_SCALE_Z     = 2'd2,
    REG_POINT_LIMIT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_HIT,
    RES_ASSIGN,
    RES_REFUSE,
    RES_IGNORE
  } res_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_REV,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_MUL_END,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                      start_new_set;
    logic [IDX_W-1:0]          old_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } vic_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]          new_index;
    logic                      is_first_use;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [CNT_W-1:0]          vertex_count;
    logic                      overflow;
  } vic_out_t;

  typedef struct packed {
    logic    load;
    logic    rev_rd;
    res_op_e res;
    logic    mul_en;
    axis_e   mul_axis;
    logic    st_en;
    axis_e   st_axis;
  } vic_cmd_t;

  typedef struct packed {
    logic in_range;
    logic hit;
    logic room;
  } vic_status_t;

  // Round to nearest (ties toward plus infinity) after dropping the
  // fraction bits, then saturate to the signed 32 bit range.
  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W-1:0]        sum;
    logic signed [PROD_W-FRAC_W-1:0] q;
    logic signed [COORD_W-1:0]       res;
    sum = prod + PROD_W'(1 << (FRAC_W - 1));
    q   = sum[PROD_W-1:FRAC_W];
    if (q > $signed((PROD_W-FRAC_W)'(32'h7FFF_FFFF))) begin
      res = 32'sh7FFF_FFFF;
    end else if (q < -$signed((PROD_W-FRAC_W)'(33'h0_8000_0000))) begin
      res = -32'sh7FFF_FFFF - 32'sd1;
    end else begin
      res = q[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/vic_ctrl.sv -----
// Sequencer of the vertex index compactor: walks each request through the
// map lookup, the decision and the per-axis scaling. Depends on vic_pkg.
module vic_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  vic_pkg::vic_status_t status_i,
  output vic_pkg::vic_cmd_t    cmd_o
);

  vic_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vic_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.res      = vic_pkg::RES_NONE;
    cmd_o.mul_axis = vic_pkg::AX_X;
    cmd_o.st_axis  = vic_pkg::AX_X;
    in_stall_o     = 1'b1;
    out_valid_o    = 1'b0;
    case (state_q)
      vic_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = vic_pkg::ST_MAP;
        end
      end
      vic_pkg::ST_MAP: begin
        cmd_o.rev_rd = 1'b1;
        state_d      = vic_pkg::ST_REV;
      end
      vic_pkg::ST_REV: begin
        state_d = vic_pkg::ST_OUT;
        if (!status_i.in_range) begin
          cmd_o.res = vic_pkg::RES_IGNORE;
        end else if (status_i.hit) begin
          cmd_o.res = vic_pkg::RES_HIT;
        end else if (status_i.room) begin
          cmd_o.res = vic_pkg::RES_ASSIGN;
          state_d   = vic_pkg::ST_MUL_X;
        end else begin
          cmd_o.res = vic_pkg::RES_REFUSE;
        end
      end
      vic_pkg::ST_MUL_X: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_axis = vic_pkg::AX_X;
        state_d        = vic_pkg::ST_MUL_Y;
      end
      vic_pkg::ST_MUL_Y: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_axis = vic_pkg::AX_Y;
        cmd_o.st_en    = 1'b1;
        cmd_o.st_axis  = vic_pkg::AX_X;
        state_d        = vic_pkg::ST_MUL_Z;
      end
      vic_pkg::ST_MUL_Z: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_axis = vic_pkg::AX_Z;
        cmd_o.st_en    = 1'b1;
        cmd_o.st_axis  = vic_pkg::AX_Y;
        state_d        = vic_pkg::ST_MUL_END;
      end
      vic_pkg::ST_MUL_END: begin
        cmd_o.st_en   = 1'b1;
        cmd_o.st_axis = vic_pkg::AX_Z;
        state_d       = vic_pkg::ST_OUT;
      end
      vic_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = vic_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vic_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/vic_dpath.sv -----
// Datapath of the vertex index compactor: configuration registers, the
// forward and reverse index maps, the vertex counter and the shared scaler.
// Depends on vic_pkg.
module vic_dpath #(
  parameter int unsigned MAX_POINTS = vic_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [vic_pkg::SCALE_W-1:0]   cfg_wdata_i,
  input  vic_pkg::vic_in_t              in_data_i,
  input  vic_pkg::vic_cmd_t             cmd_i,
  output vic_pkg::vic_status_t          status_o,
  output vic_pkg::vic_out_t             out_data_o
);

  localparam int unsigned DEPTH =
    (MAX_POINTS < vic_pkg::MAP_LIMIT) ? MAX_POINTS : vic_pkg::MAP_LIMIT;
  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned CW  = vic_pkg::CNT_W;
  localparam int unsigned IW  = vic_pkg::IDX_W;
  localparam int unsigned PW  = vic_pkg::PROD_W;

  // The maps form a sparse set: an entry is live when its forward value is
  // below the count and the reverse map points back at it. Neither memory
  // ever needs clearing, so a new set only resets the counter and the overflow flag.
  logic [AW-1:0] fwd_mem [DEPTH];
  logic [AW-1:0] rev_mem [DEPTH];

  logic [vic_pkg::SCALE_W-1:0] scale_x_q, scale_y_q, scale_z_q;
  logic [CW-1:0]               limit_q;
  logic [CW-1:0]               count_q;
  logic                        ovf_q;

  vic_pkg::vic_in_t            item_q;
  logic [AW-1:0]               fwd_rd_q;
  logic [AW-1:0]               rev_rd_q;
  logic [IW-1:0]               nidx_q;
  logic                        first_q;
  logic signed [31:0]          pos_x_q, pos_y_q, pos_z_q;
  logic signed [PW-1:0]        prod_q;

  logic [CW-1:0]               cap;
  logic [AW-1:0]               item_addr;
  logic signed [31:0]          mul_a;
  logic [vic_pkg::SCALE_W-1:0] mul_b;
  logic signed [PW-1:0]        prod_d;
  logic signed [31:0]          pos_rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= vic_pkg::SCALE_RESET;
      scale_y_q <= vic_pkg::SCALE_RESET;
      scale_z_q <= vic_pkg::SCALE_RESET;
      limit_q   <= vic_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (vic_pkg::cfg_reg_e'(cfg_addr_i))
        vic_pkg::REG_SCALE_X:     scale_x_q <= cfg_wdata_i;
        vic_pkg::REG_SCALE_Y:     scale_y_q <= cfg_wdata_i;
        vic_pkg::REG_SCALE_Z:     scale_z_q <= cfg_wdata_i;
        vic_pkg::REG_POINT_LIMIT: limit_q   <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  assign cap       = (limit_q < CW'(DEPTH)) ? limit_q : CW'(DEPTH);
  assign item_addr = item_q.old_index[AW-1:0];

  assign status_o.in_range = ({1'b0, item_q.old_index} < CW'(DEPTH));
  assign status_o.hit      = (CW'(fwd_rd_q) < count_q) && (rev_rd_q == item_addr);
  assign status_o.room     = (count_q < cap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load && in_data_i.start_new_set) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.res == vic_pkg::RES_ASSIGN) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.res == vic_pkg::RES_REFUSE) begin
      ovf_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q   <= in_data_i;
      fwd_rd_q <= fwd_mem[in_data_i.old_index[AW-1:0]];
    end
    if (cmd_i.rev_rd) begin
      rev_rd_q <= rev_mem[fwd_rd_q];
    end
    if (cmd_i.res == vic_pkg::RES_ASSIGN) begin
      fwd_mem[item_addr]       <= count_q[AW-1:0];
      rev_mem[count_q[AW-1:0]] <= item_addr;
    end
  end

  always_comb begin
    case (cmd_i.mul_axis)
      vic_pkg::AX_X: begin
        mul_a = item_q.coord_x;
        mul_b = scale_x_q;
      end
      vic_pkg::AX_Y: begin
        mul_a = item_q.coord_y;
        mul_b = scale_y_q;
      end
      vic_pkg::AX_Z: begin
        mul_a = item_q.coord_z;
        mul_b = scale_z_q;
      end
      default: begin
        mul_a = item_q.coord_x;
        mul_b = scale_x_q;
      end
    endcase
  end

  assign prod_d  = PW'(mul_a) * $signed(PW'({1'b0, mul_b}));
  assign pos_rnd = vic_pkg::round_sat(prod_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    case (cmd_i.res)
      vic_pkg::RES_HIT: nidx_q <= IW'(fwd_rd_q);
      vic_pkg::RES_ASSIGN: nidx_q <= IW'(count_q);
      vic_pkg::RES_REFUSE: nidx_q <= (cap == '0) ? '0 : IW'(cap - CW'(1));
      vic_pkg::RES_IGNORE: nidx_q <= '0;
      default: ;
    endcase
    if (cmd_i.res != vic_pkg::RES_NONE) begin
      first_q <= (cmd_i.res == vic_pkg::RES_ASSIGN);
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (cmd_i.st_en) begin
      case (cmd_i.st_axis)
        vic_pkg::AX_X: pos_x_q <= pos_rnd;
        vic_pkg::AX_Y: pos_y_q <= pos_rnd;
        vic_pkg::AX_Z: pos_z_q <= pos_rnd;
        default: ;
      endcase
    end
  end

  assign out_data_o.new_index    = nidx_q;
  assign out_data_o.is_first_use = first_q;
  assign out_data_o.pos_x        = pos_x_q;
  assign out_data_o.pos_y        = pos_y_q;
  assign out_data_o.pos_z        = pos_z_q;
  assign out_data_o.vertex_count = count_q;
  assign out_data_o.overflow     = ovf_q;

  // A new vertex is only granted with room left and no live entry. Map words
  // that were never written read as unknown, which also means no live entry.
  a_assign_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res == vic_pkg::RES_ASSIGN) |-> (status_o.room && (status_o.hit !== 1'b1)))
    else $error("vertex assigned without room or on a live entry");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res == vic_pkg::RES_ASSIGN) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("vertex counter did not advance by one");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CW'(DEPTH)))
    else $error("vertex counter beyond map depth");

  a_ovf_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> ($past(cmd_i.res) == vic_pkg::RES_REFUSE))
    else $error("overflow raised without a refused vertex");

endmodule

// ----- rtl/vertex_index_compactor_top.sv -----
// Top level of the vertex index compactor: joins the sequencer and the
// datapath. Depends on vic_pkg, vic_ctrl and vic_dpath.
//
// Each input request is one triangle corner: an old vertex index and its
// Q16.16 coordinates. The result request gives the dense new index, the
// scaled position on first use, the running vertex count and overflow.
// Both channels hand over a request when valid is high and stall is low.
// One request is in flight at a time. A corner whose vertex is already
// known, refused or out of range passes the forward map read, the reverse
// map read and the decision before its result shows. A first use then runs
// the three axes through one shared 32x25 multiplier, one axis a cycle, and
// stores each rounded axis before its result shows. A stalled result holds
// in its output register and holds off new input until taken. Reset clears
// the controller, count, overflow and configuration; the index maps need no
// clearing, because an entry counts only when the reverse map confirms it
// below the count. Configuration is written through cfg_we_i; the user
// must write it only while the block is idle; the block does not enforce it.
module vertex_index_compactor_top #(
  parameter int unsigned MAX_POINTS = vic_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_addr_i,
  input  logic [vic_pkg::SCALE_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  vic_pkg::vic_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output vic_pkg::vic_out_t           out_data_o
);

  vic_pkg::vic_cmd_t    cmd;
  vic_pkg::vic_status_t status;

  vic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vic_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule
